// ===== src/stable_priority_message_queue_macros.svh =====
// Assertion macros used by the port-level checker of the priority message queue.
`ifndef STABLE_PRIORITY_MESSAGE_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_MESSAGE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPMQ_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("spmq check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define SPMQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("spmq check failed: next-cycle implication");

`endif

// ===== src/spmq_pkg.sv =====
// Types and codes shared by the priority message queue modules.
package spmq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE   = 1'b0,
      FSM_UPDATE = 1'b1
   } fsm_state_type;

   typedef struct packed {
      logic [31:0] request;
      logic [31:0] payload;
      logic [31:0] prio;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== src/spmq_channels.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface spmq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [31:0] request_code;
   logic [31:0] payload_word;
   logic [31:0] entry_priority;
   logic [31:0] range_first;
   logic [31:0] range_last;

   modport source (output valid, operation, request_code, payload_word, entry_priority,
                   range_first, range_last, input ready);
   modport sink (input valid, operation, request_code, payload_word, entry_priority,
                 range_first, range_last, output ready);
endinterface

interface spmq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] head_request;
   logic [31:0] head_payload;
   logic [31:0] head_priority;
   logic        head_in_range;
   logic        queue_empty;

   modport source (output valid, status, head_request, head_payload, head_priority,
                   head_in_range, queue_empty, input ready);
   modport sink (input valid, status, head_request, head_payload, head_priority,
                 head_in_range, queue_empty, output ready);
endinterface

// ===== src/stable_priority_message_queue.sv =====
// At acceptance the request is captured and compared; the response register loads
// in the controller's update state, which waits while an earlier response is held.
// No new request is accepted until the captured one has been committed.
// Reset clears the slot valid bits, the controller state and the response valid flag;
// the queue is empty and ready to accept in the first cycle after reset.
module stable_priority_message_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   spmq_req_if.sink   req_if,
   spmq_rsp_if.source rsp_if
);
   import spmq_pkg::*;

   // The controller accepts a request only in its idle state. At acceptance the
   // datapath captures the request and compares the new priority against every
   // stored slot at once. In the update state that follows, the datapath shifts the
   // slots, writes the new entry, drops the head or clears the queue, and loads the
   // response register. That update waits while an earlier response is still held
   // by the sink, so a new request can be taken while a finished response is pending.

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   spmq_ctrl u_spmq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   spmq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_spmq_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .dp_status          (dp_status),
      .req_operation      (req_if.operation),
      .req_request_code   (req_if.request_code),
      .req_payload_word   (req_if.payload_word),
      .req_entry_priority (req_if.entry_priority),
      .req_range_first    (req_if.range_first),
      .req_range_last     (req_if.range_last),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_status         (rsp_if.status),
      .rsp_head_request   (rsp_if.head_request),
      .rsp_head_payload   (rsp_if.head_payload),
      .rsp_head_priority  (rsp_if.head_priority),
      .rsp_head_in_range  (rsp_if.head_in_range),
      .rsp_queue_empty    (rsp_if.queue_empty)
   );

endmodule

// ===== src/spmq_ctrl.sv =====
// Controller state machine of the priority message queue.
module spmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  spmq_pkg::dp_status_type dp_status,
   output spmq_pkg::ctrl_cmd_type  cmd
);
   import spmq_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_UPDATE;
         end
         FSM_UPDATE: begin
            if (dp_status.out_free) state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         FSM_UPDATE: begin
            cmd.commit = dp_status.out_free;
         end
      endcase
   end

endmodule

// ===== src/spmq_datapath.sv =====
// Slot array, priority compare, shift network and response register of the queue.
module spmq_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spmq_pkg::ctrl_cmd_type  cmd,
   output spmq_pkg::dp_status_type dp_status,
   input  logic [1:0]              req_operation,
   input  logic [31:0]             req_request_code,
   input  logic [31:0]             req_payload_word,
   input  logic [31:0]             req_entry_priority,
   input  logic [31:0]             req_range_first,
   input  logic [31:0]             req_range_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [31:0]             rsp_head_request,
   output logic [31:0]             rsp_head_payload,
   output logic [31:0]             rsp_head_priority,
   output logic                    rsp_head_in_range,
   output logic                    rsp_queue_empty
);
   import spmq_pkg::*;

   // Captured transaction.
   op_type      op_ff;
   entry_type   new_ff;
   logic [31:0] first_ff;
   logic [31:0] last_ff;
   logic [QUEUE_DEPTH-1:0] ge_ff, ge_in;

   // Slots, slot 0 is the head; valid bits form a thermometer code.
   entry_type              slot_ff [QUEUE_DEPTH];
   entry_type              slot_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   entry_type   rsp_head_ff, rsp_head_in;
   logic        rsp_in_range_ff, rsp_in_range_in;
   logic        rsp_empty_ff, rsp_empty_in;

   logic is_full;
   logic is_empty;

   assign is_full  = valid_ff[QUEUE_DEPTH-1];
   assign is_empty = !valid_ff[0];
   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;

   // Parallel compare of every stored priority against the incoming one.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ge_in[i] = valid_ff[i] && (slot_ff[i].prio >= req_entry_priority);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_INSERT;
      end else if (cmd.capture) begin
         op_ff <= op_type'(req_operation);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_ff.request <= req_request_code;
         new_ff.payload <= req_payload_word;
         new_ff.prio    <= req_entry_priority;
         first_ff       <= req_range_first;
         last_ff        <= req_range_last;
         ge_ff          <= ge_in;
      end
   end

   // Next slot contents and response for the captured operation.
   always_comb begin
      slot_in         = slot_ff;
      valid_in        = valid_ff;
      rsp_status_in   = ST_OK;
      rsp_head_in     = '0;
      rsp_in_range_in = 1'b0;
      rsp_empty_in    = is_empty;
      unique case (op_ff)
         OP_INSERT: begin
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               valid_in     = {valid_ff[QUEUE_DEPTH-2:0], 1'b1};
               rsp_empty_in = 1'b0;
               if (!ge_ff[0]) slot_in[0] = new_ff;
               for (int i = 1; i < QUEUE_DEPTH; i++) begin
                  if (!ge_ff[i]) slot_in[i] = ge_ff[i-1] ? new_ff : slot_ff[i-1];
               end
            end
         end
         OP_POP, OP_PEEK: begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_head_in     = slot_ff[0];
               rsp_in_range_in = (slot_ff[0].request >= first_ff) &&
                                 (slot_ff[0].request <= last_ff);
               if (op_ff == OP_POP) begin
                  valid_in     = {1'b0, valid_ff[QUEUE_DEPTH-1:1]};
                  rsp_empty_in = !valid_ff[1];
                  for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                     slot_in[i] = slot_ff[i+1];
                  end
               end
            end
         end
         OP_CLEAR: begin
            valid_in     = '0;
            rsp_empty_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_head_ff     <= rsp_head_in;
         rsp_in_range_ff <= rsp_in_range_in;
         rsp_empty_ff    <= rsp_empty_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_request  = rsp_head_ff.request;
   assign rsp_head_payload  = rsp_head_ff.payload;
   assign rsp_head_priority = rsp_head_ff.prio;
   assign rsp_head_in_range = rsp_in_range_ff;
   assign rsp_queue_empty   = rsp_empty_ff;

endmodule

// ===== src/spmq_checker.sv =====
// Port-level assertions for the priority message queue and their bind.
`include "stable_priority_message_queue_macros.svh"

module spmq_checker (
   input logic       clock,
   input logic       reset,
   spmq_req_if.sink   req_if,
   spmq_rsp_if.source rsp_if
);
   import spmq_pkg::*;

   logic req_accept;
   logic rsp_stall;
   logic empty_resp;
   logic full_resp;
   logic empty_fields_ok;
   logic full_fields_ok;

   assign req_accept      = req_if.valid && req_if.ready;
   assign rsp_stall       = rsp_if.valid && !rsp_if.ready;
   assign empty_resp      = rsp_if.valid && (rsp_if.status == ST_EMPTY);
   assign full_resp       = rsp_if.valid && (rsp_if.status == ST_FULL);
   assign empty_fields_ok = rsp_if.queue_empty && (rsp_if.head_request == 32'd0) &&
                            !rsp_if.head_in_range;
   assign full_fields_ok  = !rsp_if.queue_empty && (rsp_if.head_priority == 32'd0) &&
                            !rsp_if.head_in_range;

   `SPMQ_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_stall, rsp_if.valid)
   `SPMQ_ASSERT_NEXT(busy_after_accept_a, clock, reset, req_accept, !req_if.ready)
   `SPMQ_ASSERT_SAME(empty_status_a, clock, reset, empty_resp, empty_fields_ok)
   `SPMQ_ASSERT_SAME(full_status_a, clock, reset, full_resp, full_fields_ok)

endmodule

bind stable_priority_message_queue spmq_checker u_spmq_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);

// ===== sim/spmq_response_checker.sv =====
// Response checker for the priority message queue: tracks queue contents and compares responses.
module spmq_response_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   spmq_req_if  req_mon,
   spmq_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   awaited_count,
   output int   checked_count,
   output int   full_drop_count,
   output int   empty_count,
   output int   in_range_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spmq_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] head_request;
      logic [31:0] head_payload;
      logic [31:0] head_priority;
      logic        head_in_range;
      logic        queue_empty;
   } queue_answer_type;

   // Our own copy of the queue, slot 0 at the head.
   entry_type        held_entry [QUEUE_DEPTH];
   int               held_count;
   queue_answer_type awaited_answer [$];

   // Applies one operation to the queue copy and returns the response it must produce.
   function automatic queue_answer_type apply_queue_op(op_type op, entry_type item,
                                                       logic [31:0] range_lo,
                                                       logic [31:0] range_hi);
      queue_answer_type answer;
      int               slot;
      int               i;
      answer = '0;
      case (op)
         OP_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               answer.status = ST_FULL;
            end else begin
               // The new entry goes behind every entry of equal or higher priority.
               slot = 0;
               while (slot < held_count && held_entry[slot].prio >= item.prio) slot++;
               for (i = held_count; i > slot; i--) held_entry[i] = held_entry[i - 1];
               held_entry[slot] = item;
               held_count++;
            end
         end
         OP_POP, OP_PEEK: begin
            if (held_count == 0) begin
               answer.status = ST_EMPTY;
            end else begin
               answer.head_request  = held_entry[0].request;
               answer.head_payload  = held_entry[0].payload;
               answer.head_priority = held_entry[0].prio;
               answer.head_in_range = (held_entry[0].request >= range_lo) &&
                                      (held_entry[0].request <= range_hi);
               if (op == OP_POP) begin
                  for (i = 1; i < held_count; i++) held_entry[i - 1] = held_entry[i];
                  held_count--;
               end
            end
         end
         default: begin
            held_count = 0;
         end
      endcase
      answer.queue_empty = (held_count == 0);
      return answer;
   endfunction

   task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%08h, actual 0x%08h", field, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // Responses are retired before new requests are added, so that a stray response
   // in the same cycle as an accepted request is still caught.
   always @(posedge clock) begin
      queue_answer_type want;
      entry_type        item;
      if (reset) begin
         held_count = 0;
         awaited_answer.delete();
         mismatch_count  = 0;
         checked_count   = 0;
         full_drop_count = 0;
         empty_count     = 0;
         in_range_count  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_answer.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatch_count++;
            end else begin
               want = awaited_answer.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_mon.status));
               check_field("head_request", want.head_request, rsp_mon.head_request);
               check_field("head_payload", want.head_payload, rsp_mon.head_payload);
               check_field("head_priority", want.head_priority, rsp_mon.head_priority);
               check_field("head_in_range", 32'(want.head_in_range),
                           32'(rsp_mon.head_in_range));
               check_field("queue_empty", 32'(want.queue_empty), 32'(rsp_mon.queue_empty));
               checked_count++;
               if (want.status == ST_FULL) full_drop_count++;
               if (want.status == ST_EMPTY) empty_count++;
               if (want.head_in_range) in_range_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            item.request = req_mon.request_code;
            item.payload = req_mon.payload_word;
            item.prio    = req_mon.entry_priority;
            awaited_answer.push_back(apply_queue_op(op_type'(req_mon.operation), item,
                                                    req_mon.range_first,
                                                    req_mon.range_last));
         end
      end
      awaited_count = awaited_answer.size();
   end

endmodule

// ===== sim/tb.sv =====
// Top-level testbench of the priority message queue: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spmq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 925;
   // Generous bound for the slowest legal run, including the long receiver hold-off.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;

   spmq_req_if req_ch ();
   spmq_rsp_if rsp_ch ();

   // Idle and stall rates in percent, changed by the stimulus between phases.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // The stimulus bumps hold_asked to request one long receiver hold-off;
   // the receiver process acknowledges by copying it into hold_done.
   int hold_asked     = 0;
   int hold_done      = 0;
   int cycle_count    = 0;

   int mismatch_count;
   int awaited_count;
   int checked_count;
   int full_drop_count;
   int empty_count;
   int in_range_count;

   stable_priority_message_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   spmq_response_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) response_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .checked_count  (checked_count),
      .full_drop_count(full_drop_count),
      .empty_count    (empty_count),
      .in_range_count (in_range_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Give up if the run hangs; the checker may still be waiting on responses.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout: no progress within %0d cycles", CYCLE_LIMIT);
         $display("** stable_priority_message_queue: FAILED **");
         $finish;
      end
   end

   // Response side. Ready changes only at the falling edge. A hold-off request
   // keeps ready low while hold_left counts down from HOLD_CYCLES, so the block's
   // output register stays occupied and the request side backs up behind it.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offers one request transaction and returns at the falling edge after it has
   // been accepted. Valid stays high straight into the next call unless that call
   // decides to idle first, so each step sees at most one assignment to valid.
   task automatic send_op(op_type op, logic [31:0] code, logic [31:0] payload,
                          logic [31:0] prio, logic [31:0] range_lo,
                          logic [31:0] range_hi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.operation      <= op;
      req_ch.request_code   <= code;
      req_ch.payload_word   <= payload;
      req_ch.entry_priority <= prio;
      req_ch.range_first    <= range_lo;
      req_ch.range_last     <= range_hi;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Mostly a handful of small values so that equal priorities and in-range heads
   // are common, some extremes, and the rest anything at all.
   function automatic logic [31:0] pick_word(int narrow_pct);
      int r;
      r = $urandom_range(99);
      if (r < narrow_pct) return 32'($urandom_range(0, 7));
      if (r < narrow_pct + 15) begin
         case ($urandom_range(3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // One random transaction. The mood steers the queue towards full (mostly
   // inserts), towards empty (mostly pops) or keeps it balanced; clear is rare
   // so the queue actually reaches both ends.
   task automatic send_random_op(int mood);
      int          insert_pct;
      int          r;
      op_type      op;
      logic [31:0] range_lo;
      logic [31:0] range_hi;
      insert_pct = (mood == 0) ? 75 : (mood == 1) ? 25 : 50;
      r = $urandom_range(99);
      if (r < 3) op = OP_CLEAR;
      else if (r < 3 + insert_pct) op = OP_INSERT;
      else op = ($urandom_range(2) == 0) ? OP_PEEK : OP_POP;
      r = $urandom_range(99);
      if (r < 40) begin
         range_lo = 32'($urandom_range(0, 7));
         range_hi = 32'($urandom_range(0, 7));
      end else if (r < 55) begin
         range_lo = 32'h0000_0000;
         range_hi = 32'hFFFF_FFFF;
      end else begin
         range_lo = $urandom;
         range_hi = $urandom;
      end
      send_op(op, pick_word(45), $urandom, pick_word(50), range_lo, range_hi);
   endtask

   initial begin
      int phase;
      int n;
      int i;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.operation      <= OP_INSERT;
      req_ch.request_code   <= '0;
      req_ch.payload_word   <= '0;
      req_ch.entry_priority <= '0;
      req_ch.range_first    <= '0;
      req_ch.range_last     <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Pop and peek on the empty queue report status empty.
      send_op(OP_POP, $urandom, $urandom, $urandom, 32'h0, 32'hFFFF_FFFF);
      send_op(OP_PEEK, $urandom, $urandom, $urandom, 32'h0, 32'hFFFF_FFFF);
      // Fill the queue: one all-zero entry, one all-ones entry, and the rest on
      // three shared priorities so that arrival order among equals is exercised.
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         if (i == 0) send_op(OP_INSERT, 32'h0, 32'h0, 32'h0, $urandom, $urandom);
         else if (i == 1)
            send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    $urandom, $urandom);
         else send_op(OP_INSERT, 32'(i), $urandom, 32'(i % 3), $urandom, $urandom);
      end
      // An insert into the full queue is dropped.
      send_op(OP_INSERT, 32'h1234_5678, $urandom, 32'hFFFF_FFFF, $urandom, $urandom);
      // The all-ones head sits exactly on a one-value range at the top.
      send_op(OP_PEEK, $urandom, $urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // A range whose lower bound is above its upper bound contains nothing.
      send_op(OP_POP, $urandom, $urandom, $urandom, 32'h5, 32'h2);
      send_op(OP_POP, $urandom, $urandom, $urandom, 32'h0, 32'hFFFF_FFFF);
      // Clear from a nearly full queue, peek the empty result, clear again when empty.
      send_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_op(OP_PEEK, $urandom, $urandom, $urandom, 32'h0, 32'hFFFF_FFFF);
      send_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);

      // Random part in four idling phases. The mood changes every 40 transactions,
      // which drives the queue repeatedly from empty to full and back.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 78;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 78;
            end
            default: begin
               send_idle_pct  = 30;
               recv_stall_pct = 30;
            end
         endcase
         for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
            // With no idling otherwise, a long receiver hold-off backs the block up.
            if (phase == 0 && n == 60) hold_asked++;
            send_random_op((n / 40) % 3);
         end
      end
      req_ch.valid <= 1'b0;

      // Let the last responses drain, then keep watching for strays before the verdict.
      while (awaited_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d responses: %0d dropped on a full queue, %0d on an empty queue,",
               checked_count, full_drop_count, empty_count);
      $display("%0d heads within range; %0d mismatches, %0d responses outstanding.",
               in_range_count, mismatch_count, awaited_count);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("** stable_priority_message_queue: PASSED **");
      end else begin
         $display("** stable_priority_message_queue: FAILED **");
      end
      $finish;
   end

endmodule
